[hdl/l4_payload_xor_csum_fixup_assert.svh]
// ----------------------------------------------------------------------------
// l4_payload_xor_csum_fixup assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef L4_PAYLOAD_XOR_CSUM_FIXUP_ASSERT_SVH
`define L4_PAYLOAD_XOR_CSUM_FIXUP_ASSERT_SVH

// checked outside reset
`define L4XCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define L4XCS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/l4xcs_pkg.sv]
// ----------------------------------------------------------------------------
// l4xcs_pkg
// types, constants and one's-complement helpers of the payload xor fixup
// ----------------------------------------------------------------------------
package l4xcs_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CsumW    = 16;
  localparam int unsigned PosW     = 16;
  localparam int unsigned LenW     = 6;
  localparam int unsigned OutDataW = 32;

  localparam logic [ByteW-1:0] ProtoTcp = 8'd6;
  localparam logic [ByteW-1:0] ProtoUdp = 8'd17;

  localparam logic [LenW-1:0] UdpHdrLen = 6'd8;
  localparam logic [LenW-1:0] TcpHdrMin = 6'd20;

  localparam logic [CsumW-1:0] CsumAllOnes = 16'hffff;
  localparam logic [PosW-1:0]  PosMax      = 16'hffff;

  typedef enum logic {
    KindByte    = 1'b0,
    KindTrailer = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic bypass;
    logic drop;
    logic skip;
    logic hdr;
  } pkt_flags_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             wr;
    logic             drop;
    logic             udp;
    logic [CsumW-1:0] orig;
    logic [CsumW-1:0] old_sum;
    logic [CsumW-1:0] new_sum;
  } l4xcs_item_t;

  function automatic logic [CsumW-1:0] oc_add(input logic [CsumW-1:0] a,
                                               input logic [CsumW-1:0] b);
    logic [CsumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CsumW-1:0] + {{(CsumW-1){1'b0}}, s[CsumW]};
  endfunction

  function automatic logic [CsumW-1:0] oc_add3(input logic [CsumW-1:0] a,
                                                input logic [CsumW-1:0] b,
                                                input logic [CsumW-1:0] c);
    logic [CsumW+1:0] s;
    logic [CsumW:0]   t;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    t = {1'b0, s[CsumW-1:0]} + {{(CsumW-1){1'b0}}, s[CsumW+1:CsumW]};
    return t[CsumW-1:0] + {{(CsumW-1){1'b0}}, t[CsumW]};
  endfunction

endpackage

[hdl/l4_payload_xor_csum_fixup.sv]
// ----------------------------------------------------------------------------
// l4_payload_xor_csum_fixup
// ipv4 l4 payload xor scrambler with incremental l4 checksum fixup
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while s_axis_tready is high and returns one
// byte transfer per input byte, via the staging and output registers. The last
// byte of a packet is followed by a trailer transfer (tuser high) with verdict
// and new checksum; that byte stays in the staging register for the trailer,
// so the input is held meanwhile. The trailer checksum is folded from the
// staging register into the output register. The cfg channel is always ready;
// the user must write xor_mask only while the block is idle (not enforced).
module l4_payload_xor_csum_fixup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] packet_byte
  input  logic        s_axis_tlast,  // last_byte
  input  logic [0:0]  s_axis_tuser,  // [0] checksum_offloaded
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] out_byte, [23:8] new_checksum,
                                     // [24] checksum_write, [25] verdict_drop
  output logic        m_axis_tlast,  // run_last
  output logic [0:0]  m_axis_tuser,  // [0] item_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i     // [7:0] xor_mask
);
  import l4xcs_pkg::*;

  logic [ByteW-1:0] mask_q;
  logic             in_xfer;
  logic             in_ready;
  l4xcs_item_t      item;

  assign cfg_ready_o   = 1'b1;
  assign in_xfer       = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_valid_i) begin
      mask_q <= cfg_data_i;
    end
  end

  l4xcs_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .offl_i   (s_axis_tuser[0]),
    .mask_i   (mask_q),
    .item_o   (item)
  );

  l4xcs_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_xfer),
    .item_i    (item),
    .ready_o   (in_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_kind_o  (m_axis_tuser[0]),
    .m_last_o  (m_axis_tlast)
  );

endmodule

[hdl/l4xcs_parse.sv]
// ----------------------------------------------------------------------------
// l4xcs_parse
// per-packet header parser, payload xor and running one's-complement sums
// ----------------------------------------------------------------------------
module l4xcs_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [l4xcs_pkg::ByteW-1:0] byte_i,
  input  logic                        last_i,
  input  logic                        offl_i,
  input  logic [l4xcs_pkg::ByteW-1:0] mask_i,
  output l4xcs_pkg::l4xcs_item_t      item_o
);
  import l4xcs_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [LenW-1:0]    ihl_q, ihl_d;
  logic [ByteW-1:0]   proto_q, proto_d;
  logic [LenW-1:0]    l4len_q, l4len_d;
  logic [CsumW-1:0]   orig_q, orig_d;
  logic [CsumW-1:0]   old_sum_q, old_sum_d;
  logic [CsumW-1:0]   new_sum_q, new_sum_d;
  logic [2*ByteW:0]   held_q, held_d;
  pkt_flags_t         flags_q, flags_d;

  logic [PosW-1:0]    off;
  logic               active;
  logic               payload;
  logic [ByteW-1:0]   res;
  logic               add_en;
  logic [CsumW-1:0]   w_old, w_new;

  always_comb begin
    ihl_d   = ihl_q;
    proto_d = proto_q;
    l4len_d = l4len_q;
    orig_d  = orig_q;
    flags_d = flags_q;
    held_d  = held_q;
    res     = byte_i;
    add_en  = 1'b0;
    w_old   = '0;
    w_new   = '0;

    if (pos_q == 16'd0) begin
      ihl_d = {byte_i[3:0], 2'b00};
      if (byte_i[3:0] < 4'd5) flags_d.bypass = 1'b1;
      if (offl_i) flags_d.skip = 1'b1;
    end else if (pos_q == 16'd6) begin
      if (byte_i[4:0] != 5'd0) flags_d.bypass = 1'b1;
    end else if (pos_q == 16'd7) begin
      if (byte_i != 8'd0) flags_d.bypass = 1'b1;
    end else if (pos_q == 16'd9) begin
      proto_d = byte_i;
      if (byte_i == ProtoUdp) begin
        l4len_d = UdpHdrLen;
      end else if (byte_i == ProtoTcp) begin
        l4len_d = TcpHdrMin;
      end else begin
        flags_d.bypass = 1'b1;
      end
    end

    off     = pos_q - {{(PosW-LenW){1'b0}}, ihl_d};
    active  = !flags_d.bypass && !flags_d.drop && (pos_q >= 16'd10) &&
              (pos_q >= {{(PosW-LenW){1'b0}}, ihl_d});
    payload = active && (off >= {{(PosW-LenW){1'b0}}, l4len_d});

    if (active && !payload) begin
      if (proto_d == ProtoUdp) begin
        if (off == 16'd4 || off == 16'd6) begin
          orig_d = {byte_i, 8'h00};
        end else if (off == 16'd5) begin
          if ({orig_q[15:8], orig_q[7:0] | byte_i} < 16'd8) flags_d.drop = 1'b1;
        end else if (off == 16'd7) begin
          orig_d = {orig_q[15:8], orig_q[7:0] | byte_i};
          if ({orig_q[15:8], orig_q[7:0] | byte_i} == 16'd0) flags_d.skip = 1'b1;
          flags_d.hdr = 1'b1;
        end
      end else begin
        if (off == 16'd12) begin
          l4len_d = {byte_i[7:4], 2'b00};
          if ({byte_i[7:4], 2'b00} < TcpHdrMin) flags_d.drop = 1'b1;
        end else if (off == 16'd16) begin
          orig_d = {byte_i, 8'h00};
        end else if (off == 16'd17) begin
          orig_d = {orig_q[15:8], orig_q[7:0] | byte_i};
        end
        if (!flags_d.drop &&
            ({1'b0, off} + 17'd1) == {{(PosW+1-LenW){1'b0}}, l4len_d}) begin
          flags_d.hdr = 1'b1;
        end
      end
    end

    if (payload) begin
      res = byte_i ^ mask_i;
      if (held_q[2*ByteW]) begin
        add_en = 1'b1;
        w_old  = {held_q[2*ByteW-1:ByteW], byte_i};
        w_new  = {held_q[ByteW-1:0], byte_i ^ mask_i};
        held_d = '0;
      end else begin
        held_d = {1'b1, byte_i, byte_i ^ mask_i};
        if (last_i) begin
          add_en = 1'b1;
          w_old  = {byte_i, 8'h00};
          w_new  = {byte_i ^ mask_i, 8'h00};
        end
      end
    end else if (last_i && held_q[2*ByteW]) begin
      add_en = 1'b1;
      w_old  = {held_q[2*ByteW-1:ByteW], 8'h00};
      w_new  = {held_q[ByteW-1:0], 8'h00};
    end

    old_sum_d = add_en ? oc_add(old_sum_q, w_old) : old_sum_q;
    new_sum_d = add_en ? oc_add(new_sum_q, w_new) : new_sum_q;
    pos_d     = (pos_q == PosMax) ? pos_q : pos_q + 16'd1;
  end

  always_comb begin
    item_o.out_byte = res;
    item_o.last     = last_i;
    item_o.wr       = !flags_d.bypass && !flags_d.drop && flags_d.hdr && !flags_d.skip;
    item_o.drop     = !flags_d.bypass && (flags_d.drop || !flags_d.hdr);
    item_o.udp      = (proto_d == ProtoUdp);
    item_o.orig     = orig_d;
    item_o.old_sum  = old_sum_d;
    item_o.new_sum  = new_sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ihl_q     <= '0;
      proto_q   <= '0;
      l4len_q   <= '0;
      orig_q    <= '0;
      old_sum_q <= '0;
      new_sum_q <= '0;
      held_q    <= '0;
      flags_q   <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        pos_q     <= '0;
        ihl_q     <= '0;
        proto_q   <= '0;
        l4len_q   <= '0;
        orig_q    <= '0;
        old_sum_q <= '0;
        new_sum_q <= '0;
        held_q    <= '0;
        flags_q   <= '0;
      end else begin
        pos_q     <= pos_d;
        ihl_q     <= ihl_d;
        proto_q   <= proto_d;
        l4len_q   <= l4len_d;
        orig_q    <= orig_d;
        old_sum_q <= old_sum_d;
        new_sum_q <= new_sum_d;
        held_q    <= held_d;
        flags_q   <= flags_d;
      end
    end
  end

endmodule

[hdl/l4xcs_out.sv]
// ----------------------------------------------------------------------------
// l4xcs_out
// staging register, trailer checksum and output register
// ----------------------------------------------------------------------------
module l4xcs_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  l4xcs_pkg::l4xcs_item_t         item_i,
  output logic                           ready_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [l4xcs_pkg::OutDataW-1:0] m_data_o,
  output logic                           m_kind_o,
  output logic                           m_last_o
);
  import l4xcs_pkg::*;

  logic                stg_valid_q;
  logic                stg_phase_q;
  l4xcs_item_t         stg_q;
  logic                out_valid_q;
  logic                out_last_q;
  item_kind_e          out_kind_q;
  logic [OutDataW-1:0] out_data_q;

  logic                out_free;
  logic                adv;
  logic                stg_done;
  logic [CsumW-1:0]    csum_raw;
  logic [CsumW-1:0]    csum;

  assign out_free = !out_valid_q || m_ready_i;
  assign adv      = stg_valid_q && out_free;
  assign stg_done = adv && (!stg_q.last || stg_phase_q);
  assign ready_o  = !stg_valid_q || stg_done;

  always_comb begin
    csum_raw = ~oc_add3(~stg_q.orig, ~stg_q.old_sum, stg_q.new_sum);
    if (!stg_q.wr) begin
      csum = '0;
    end else if (stg_q.udp && csum_raw == '0) begin
      csum = CsumAllOnes;
    end else begin
      csum = csum_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      stg_phase_q <= 1'b0;
    end else if (load_i) begin
      stg_valid_q <= 1'b1;
      stg_phase_q <= 1'b0;
    end else if (stg_done) begin
      stg_valid_q <= 1'b0;
      stg_phase_q <= 1'b0;
    end else if (adv) begin
      stg_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stg_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (stg_phase_q) begin
        out_kind_q <= KindTrailer;
        out_last_q <= 1'b1;
        out_data_q <= {6'd0, stg_q.drop, stg_q.wr, csum, 8'h00};
      end else begin
        out_kind_q <= KindByte;
        out_last_q <= !stg_q.last;
        out_data_q <= {{(OutDataW-ByteW){1'b0}}, stg_q.out_byte};
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_kind_o  = out_kind_q;
  assign m_last_o  = out_last_q;

endmodule

[hdl/l4xcs_checker.sv]
// ----------------------------------------------------------------------------
// l4xcs_checker
// port-level assertions of the payload xor fixup, bound to the top level
// ----------------------------------------------------------------------------
`include "l4_payload_xor_csum_fixup_assert.svh"

module l4xcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [7:0]  cfg_data_i
);

  logic        out_stall;
  logic        out_trailer;
  logic        byte_xfer;
  logic [33:0] out_word;
  logic [7:0]  out_byte;
  logic [15:0] new_csum;
  logic        csum_wr;
  logic        verdict_drop;
  logic        wr_ok;

  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign out_trailer  = m_axis_tvalid && m_axis_tuser[0];
  assign byte_xfer    = m_axis_tvalid && !m_axis_tuser[0];
  assign out_word     = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign out_byte     = m_axis_tdata[7:0];
  assign new_csum     = m_axis_tdata[23:8];
  assign csum_wr      = m_axis_tdata[24];
  assign verdict_drop = m_axis_tdata[25];
  assign wr_ok        = !(csum_wr && verdict_drop) && (csum_wr || new_csum == 16'd0);

  `L4XCS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "held transfer changed")
  `L4XCS_ASSERT(a_trailer_last, out_trailer |-> m_axis_tlast && out_byte == 8'h00, "bad trailer")
  `L4XCS_ASSERT(a_byte_clean, byte_xfer |-> m_axis_tdata[31:8] == 24'd0, "stray trailer fields")
  `L4XCS_ASSERT(a_wr_drop, m_axis_tvalid |-> wr_ok, "checksum write with drop or stray checksum")
  `L4XCS_ASSERT_RST(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

endmodule

bind l4_payload_xor_csum_fixup l4xcs_checker u_checker (.*);
